[rtl/gmps_pkg.sv]
`timescale 1ns / 1ps
package gmps_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int VALUE_BITS = 16;

  localparam int RB     = $clog2(MAX_ROWS);
  localparam int CB     = $clog2(MAX_COLS);
  localparam int AW     = RB + CB;
  localparam int DEPTH  = 2 ** AW;
  localparam int NR_W   = $clog2(MAX_ROWS + 1);
  localparam int NC_W   = $clog2(MAX_COLS + 1);
  localparam int TW     = VALUE_BITS + $clog2(MAX_ROWS + MAX_COLS);
  localparam int SW     = TW + 2;
  localparam int OUT_W  = 25;
  localparam int REG_W  = 7;
  localparam int IDX_W  = 1;

  localparam logic [IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [IDX_W-1:0] REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    PASS_TL,
    PASS_TR,
    PASS_BL,
    PASS_BR
  } pass_e;

endpackage

[rtl/gmps_cell_if.sv]
`timescale 1ns / 1ps
interface gmps_cell_if;
  logic                             valid;
  logic                             ready;
  logic [gmps_pkg::VALUE_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

[rtl/gmps_total_if.sv]
`timescale 1ns / 1ps
interface gmps_total_if;
  logic                        valid;
  logic                        ready;
  logic [gmps_pkg::OUT_W-1:0] best_total;

  modport source (output valid, output best_total, input ready);
  modport sink   (input valid, input best_total, output ready);
endinterface

[rtl/gmps_ram.sv]
`timescale 1ns / 1ps
module gmps_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [W-1:0]             rdata_a_o,
  output logic [W-1:0]             rdata_b_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[rtl/gmps_cell.sv]
`timescale 1ns / 1ps
module gmps_cell (
  input  logic                    clk_i,
  input  logic                    shift_i,
  input  logic                    entry_i,
  input  logic [gmps_pkg::TW-1:0] new_i,
  input  logic [gmps_pkg::TW-1:0] next_i,
  output logic [gmps_pkg::TW-1:0] val_o
);

  logic [gmps_pkg::TW-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (shift_i) begin
      val_d = entry_i ? new_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

[rtl/grid_meeting_paths_max_sum_core.sv]
`timescale 1ns / 1ps
// channel   | dir | payload            | request moves
// cell_i    | in  | cell_value [15:0]  | one grid cell, row-major
// total_o   | out | best_total [24:0]  | one total per finished grid
// cfg_*     | in  | rows / cols [6:0]  | size write, clears partial grid
// a grid of R x C cells is loaded, then four table sweeps run over the cell
// memory, then the pipeline drains through ST_DRAIN1 and ST_DRAIN2 to the result
// the last sweep also scores the meeting cells
// rows of the tables run through a chain of MAX_COLS cells holding the row above
// rst_ni clears control state; memories hold no valid bits
// cell_i is not ready while a grid is processed or the result waits
module grid_meeting_paths_max_sum_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gmps_cell_if.sink                    cell_i,
  gmps_total_if.source                 total_o,
  input  logic                         cfg_we_i,
  input  logic [gmps_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [gmps_pkg::REG_W-1:0]   cfg_data_i
);

  localparam int RB = gmps_pkg::RB;
  localparam int CB = gmps_pkg::CB;
  localparam int AW = gmps_pkg::AW;
  localparam int TW = gmps_pkg::TW;
  localparam int SW = gmps_pkg::SW;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_OUT
  } state_e;

  state_e                         state_q;
  gmps_pkg::pass_e                pass_q, pass_nx;
  logic [gmps_pkg::REG_W-1:0]     rows_q, cols_q;
  logic [gmps_pkg::NR_W-1:0]      nr;
  logic [gmps_pkg::NC_W-1:0]      nc;
  logic [RB-1:0]                  last_r, r_q, i_q;
  logic [CB-1:0]                  last_c, c_q, j_q;
  logic                           acc, last_cell;
  logic                           down, right, nx_down, nx_right;
  logic [RB-1:0]                  row_start, row_end, nx_row_start;
  logic [CB-1:0]                  col_start, col_end, nx_col_start;
  logic [RB-1:0]                  im1, ip1;
  logic [CB-1:0]                  jm1, jp1;
  logic                           iss_v, iss_int;

  logic                           st_v_q, st_frow_q, st_fcol_q, st_int_q;
  gmps_pkg::pass_e                st_pass_q;
  logic [RB-1:0]                  st_i_q;
  logic [CB-1:0]                  st_j_q;
  logic [AW-1:0]                  st_addr;

  logic [gmps_pkg::VALUE_BITS-1:0] cell_rd;
  logic [TW-1:0]                  tl_a, tl_b, bl_a, bl_b, tr_a, tr_b;
  logic [TW-1:0]                  above, prev, prev_q, v;
  logic [TW-1:0]                  chain_val [gmps_pkg::MAX_COLS];
  logic                           sm_v_q;
  logic [SW-1:0]                  across_q, down_q, best_q, blk_max;

  // effective sizes
  always_comb begin
    if (rows_q == '0) begin
      nr = gmps_pkg::NR_W'(1);
    end else if (32'(rows_q) > gmps_pkg::MAX_ROWS) begin
      nr = gmps_pkg::NR_W'(gmps_pkg::MAX_ROWS);
    end else begin
      nr = gmps_pkg::NR_W'(rows_q);
    end
    if (cols_q == '0) begin
      nc = gmps_pkg::NC_W'(1);
    end else if (32'(cols_q) > gmps_pkg::MAX_COLS) begin
      nc = gmps_pkg::NC_W'(gmps_pkg::MAX_COLS);
    end else begin
      nc = gmps_pkg::NC_W'(cols_q);
    end
  end

  assign last_r = RB'(nr - 1'b1);
  assign last_c = CB'(nc - 1'b1);

  // a size write takes the cycle, no cell is taken with it
  assign cell_i.ready   = (state_q == ST_LOAD) && !cfg_we_i;
  assign acc            = cell_i.valid && cell_i.ready;
  assign last_cell      = (r_q == last_r) && (c_q == last_c);
  assign total_o.valid  = (state_q == ST_OUT);
  assign total_o.best_total = gmps_pkg::OUT_W'(best_q);

  // sweep directions
  assign pass_nx      = gmps_pkg::pass_e'(pass_q + 2'd1);
  assign down         = (pass_q == gmps_pkg::PASS_TL) || (pass_q == gmps_pkg::PASS_TR);
  assign right        = (pass_q == gmps_pkg::PASS_TL) || (pass_q == gmps_pkg::PASS_BL);
  assign nx_down      = (pass_nx == gmps_pkg::PASS_TL) || (pass_nx == gmps_pkg::PASS_TR);
  assign nx_right     = (pass_nx == gmps_pkg::PASS_TL) || (pass_nx == gmps_pkg::PASS_BL);
  assign row_start    = down ? '0 : last_r;
  assign row_end      = down ? last_r : '0;
  assign col_start    = right ? '0 : last_c;
  assign col_end      = right ? last_c : '0;
  assign nx_row_start = nx_down ? '0 : last_r;
  assign nx_col_start = nx_right ? '0 : last_c;

  assign im1 = i_q - 1'b1;
  assign ip1 = i_q + 1'b1;
  assign jm1 = j_q - 1'b1;
  assign jp1 = j_q + 1'b1;

  assign iss_v   = (state_q == ST_PASS);
  assign iss_int = (pass_q == gmps_pkg::PASS_BR) && (i_q != '0) && (i_q != last_r)
                   && (j_q != '0) && (j_q != last_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pass_q  <= gmps_pkg::PASS_TL;
      rows_q  <= gmps_pkg::REG_W'(64);
      cols_q  <= gmps_pkg::REG_W'(64);
      r_q     <= '0;
      c_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == gmps_pkg::REG_ROWS) begin
          rows_q <= cfg_data_i;
        end else begin
          cols_q <= cfg_data_i;
        end
        r_q <= '0;
        c_q <= '0;
      end
      case (state_q)
        ST_LOAD: begin
          if (acc) begin
            if (c_q == last_c) begin
              c_q <= '0;
              if (r_q == last_r) begin
                r_q     <= '0;
                state_q <= ST_PASS;
                pass_q  <= gmps_pkg::PASS_TL;
                i_q     <= '0;
                j_q     <= '0;
              end else begin
                r_q <= r_q + 1'b1;
              end
            end else begin
              c_q <= c_q + 1'b1;
            end
          end
        end
        ST_PASS: begin
          if (j_q == col_end) begin
            if (i_q == row_end) begin
              if (pass_q == gmps_pkg::PASS_BR) begin
                state_q <= ST_DRAIN1;
                j_q     <= col_start;
              end else begin
                pass_q <= pass_nx;
                i_q    <= nx_row_start;
                j_q    <= nx_col_start;
              end
            end else begin
              j_q <= col_start;
              i_q <= down ? ip1 : im1;
            end
          end else begin
            j_q <= right ? jp1 : jm1;
          end
        end
        ST_DRAIN1: state_q <= ST_DRAIN2;
        ST_DRAIN2: state_q <= ST_OUT;
        ST_OUT: begin
          if (total_o.ready) begin
            state_q <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // issue to compute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= 1'b0;
      sm_v_q <= 1'b0;
    end else begin
      st_v_q <= iss_v;
      sm_v_q <= st_v_q && st_int_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_pass_q <= pass_q;
    st_i_q    <= i_q;
    st_j_q    <= j_q;
    st_frow_q <= (i_q == row_start);
    st_fcol_q <= (j_q == col_start);
    st_int_q  <= iss_int;
    if (st_v_q) begin
      prev_q <= v;
    end
    across_q <= SW'(tl_a) + SW'(prev) + SW'(bl_a) + SW'(tr_a);
    down_q   <= SW'(tl_b) + SW'(above) + SW'(bl_b) + SW'(tr_b);
    if (acc && last_cell) begin
      best_q <= '0;
    end else if (sm_v_q && (blk_max > best_q)) begin
      best_q <= blk_max;
    end
  end

  assign blk_max = (across_q > down_q) ? across_q : down_q;
  assign st_addr = {st_i_q, st_j_q};
  assign above   = st_frow_q ? '0 : chain_val[0];
  assign prev    = st_fcol_q ? '0 : prev_q;
  assign v       = TW'(cell_rd) + ((above > prev) ? above : prev);

  // row-above chain, entry at cell nc-1, tap at cell 0
  for (genvar k = 0; k < gmps_pkg::MAX_COLS; k++) begin : g_chain
    logic [TW-1:0] nxt;
    if (k == gmps_pkg::MAX_COLS - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = chain_val[k+1];
    end
    gmps_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (st_v_q),
      .entry_i (last_c == CB'(k)),
      .new_i   (v),
      .next_i  (nxt),
      .val_o   (chain_val[k])
    );
  end

  gmps_ram #(.W(gmps_pkg::VALUE_BITS), .DEPTH(gmps_pkg::DEPTH)) u_cells (
    .clk_i     (clk_i),
    .we_i      (acc),
    .waddr_i   ({r_q, c_q}),
    .wdata_i   (cell_i.cell_value),
    .raddr_a_i ({i_q, j_q}),
    .raddr_b_i ({i_q, j_q}),
    .rdata_a_o (cell_rd),
    .rdata_b_o ()
  );

  gmps_ram #(.W(TW), .DEPTH(gmps_pkg::DEPTH)) u_tl (
    .clk_i     (clk_i),
    .we_i      (st_v_q && (st_pass_q == gmps_pkg::PASS_TL)),
    .waddr_i   (st_addr),
    .wdata_i   (v),
    .raddr_a_i ({i_q, jm1}),
    .raddr_b_i ({im1, j_q}),
    .rdata_a_o (tl_a),
    .rdata_b_o (tl_b)
  );

  gmps_ram #(.W(TW), .DEPTH(gmps_pkg::DEPTH)) u_bl (
    .clk_i     (clk_i),
    .we_i      (st_v_q && (st_pass_q == gmps_pkg::PASS_BL)),
    .waddr_i   (st_addr),
    .wdata_i   (v),
    .raddr_a_i ({ip1, j_q}),
    .raddr_b_i ({i_q, jm1}),
    .rdata_a_o (bl_a),
    .rdata_b_o (bl_b)
  );

  gmps_ram #(.W(TW), .DEPTH(gmps_pkg::DEPTH)) u_tr (
    .clk_i     (clk_i),
    .we_i      (st_v_q && (st_pass_q == gmps_pkg::PASS_TR)),
    .waddr_i   (st_addr),
    .wdata_i   (v),
    .raddr_a_i ({im1, j_q}),
    .raddr_b_i ({i_q, jp1}),
    .rdata_a_o (tr_a),
    .rdata_b_o (tr_b)
  );

  a_no_load_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(total_o.valid && cell_i.ready))
    else $error("result pending while cells accepted");

  a_sweep_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_v_q |-> (st_i_q <= last_r) && (st_j_q <= last_c))
    else $error("sweep outside grid");

  a_best_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sm_v_q |=> best_q >= $past(best_q))
    else $error("best total decreased");

  a_out_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(total_o.valid) |-> $past(state_q == ST_DRAIN2))
    else $error("result raised before pipeline drained");

endmodule
